FILE: design/parallel_printer_port_emulation_defines.svh
// Assertion macros shared by the printer port design.
`ifndef PARALLEL_PRINTER_PORT_EMULATION_DEFINES_SVH
`define PARALLEL_PRINTER_PORT_EMULATION_DEFINES_SVH

// Check a property outside of reset.
`define PPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ppe_pkg.sv
package ppe_pkg;

  localparam int unsigned NUM_PORTS  = 3;
  localparam int unsigned PORT_IDX_W = 2;

  localparam logic [15:0] PORT_BASE [NUM_PORTS] = '{16'h0378, 16'h0278, 16'h03BC};

  // Register offsets within one port
  typedef enum logic [1:0] {
    OFF_DATA    = 2'd0,
    OFF_STATUS  = 2'd1,
    OFF_CONTROL = 2'd2
  } reg_off_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_PORT_ENABLE  = 1'b0,
    CFG_RECORD_LIMIT = 1'b1
  } cfg_idx_t;

  // Status and control bit positions
  localparam int unsigned ST_SLCT_BIT    = 4;
  localparam int unsigned ST_NOTBUSY_BIT = 7;
  localparam int unsigned CT_STROBE_BIT  = 0;
  localparam int unsigned CT_INIT_BIT    = 2;
  localparam int unsigned CT_SLCTIN_BIT  = 3;

  localparam logic [7:0]  LINE_FEED     = 8'h0A;
  localparam logic [7:0]  STATUS_RESET  = 8'h90;
  localparam logic [7:0]  CONTROL_RESET = 8'h0C;
  localparam logic [15:0] MAX_RECORD    = 16'd32768;
  localparam logic [NUM_PORTS-1:0] PORT_ENABLE_RESET = '1;

  typedef struct packed {
    logic        kind;
    logic [15:0] io_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [PORT_IDX_W-1:0] port;
    reg_off_t              offset;
  } decode_t;

  typedef struct packed {
    logic                  hit;
    logic [PORT_IDX_W-1:0] port_number;
    logic [7:0]            read_data;
    logic                  byte_valid;
    logic [7:0]            out_byte;
    logic                  record_end;
    logic                  init_pulse;
  } result_t;

endpackage

FILE: design/ppe_in_if.sv
interface ppe_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] io_address;
  logic [7:0]  write_data;

  modport source (output valid, kind, io_address, write_data, input ready);
  modport sink (input valid, kind, io_address, write_data, output ready);
endinterface

FILE: design/ppe_out_if.sv
interface ppe_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] port_number;
  logic [7:0] read_data;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       record_end;
  logic       init_pulse;

  modport source (output valid, hit, port_number, read_data, byte_valid, out_byte,
                  record_end, init_pulse, input ready);
  modport sink (input valid, hit, port_number, read_data, byte_valid, out_byte,
                record_end, init_pulse, output ready);
endinterface

FILE: design/ppe_decode.sv
module ppe_decode (
  input  logic [15:0]                    io_address,
  input  logic [ppe_pkg::NUM_PORTS-1:0]  port_enable,
  output ppe_pkg::decode_t               dec
);

  logic [15:0] off;

  // Match the first enabled port whose window holds the address (unsigned)
  always_comb begin
    dec = '0;
    off = '0;
    for (int k = ppe_pkg::NUM_PORTS - 1; k >= 0; k--) begin
      off = io_address - ppe_pkg::PORT_BASE[k];
      if (port_enable[k] && io_address >= ppe_pkg::PORT_BASE[k] && off < 16'd3) begin
        dec.hit    = 1'b1;
        dec.port   = ppe_pkg::PORT_IDX_W'(k);
        dec.offset = ppe_pkg::reg_off_t'(off[1:0]);
      end
    end
  end

endmodule

FILE: design/ppe_port_regs.sv
module ppe_port_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              kind,
  input  logic [7:0]        write_data,
  input  ppe_pkg::decode_t  dec,
  input  logic [15:0]       record_limit,
  output ppe_pkg::result_t  res
);

  logic [7:0]  data_r    [ppe_pkg::NUM_PORTS];
  logic [7:0]  status_r  [ppe_pkg::NUM_PORTS];
  logic [7:0]  control_r [ppe_pkg::NUM_PORTS];
  logic [15:0] fill_r    [ppe_pkg::NUM_PORTS];
  logic [7:0]  data_nxt    [ppe_pkg::NUM_PORTS];
  logic [7:0]  status_nxt  [ppe_pkg::NUM_PORTS];
  logic [7:0]  control_nxt [ppe_pkg::NUM_PORTS];
  logic [15:0] fill_nxt    [ppe_pkg::NUM_PORTS];
  logic [15:0] fill_inc;
  logic        strobe_go;

  // Work out the result beat and the addressed port's next registers
  always_comb begin
    data_nxt    = data_r;
    status_nxt  = status_r;
    control_nxt = control_r;
    fill_nxt    = fill_r;
    res         = '0;
    fill_inc    = fill_r[dec.port] + 16'd1;
    strobe_go   = 1'b0;
    if (dec.hit) begin
      res.hit         = 1'b1;
      res.port_number = dec.port;
      if (!kind) begin
        unique case (dec.offset)
          ppe_pkg::OFF_DATA:    res.read_data = data_r[dec.port];
          ppe_pkg::OFF_STATUS:  res.read_data = status_r[dec.port];
          ppe_pkg::OFF_CONTROL: res.read_data = control_r[dec.port];
          default:              res.read_data = '0;
        endcase
      end else begin
        unique case (dec.offset)
          ppe_pkg::OFF_DATA: data_nxt[dec.port] = write_data;
          ppe_pkg::OFF_CONTROL: begin
            if (!write_data[ppe_pkg::CT_INIT_BIT]) begin
              // INIT low: request initialization, restart the record
              fill_nxt[dec.port] = '0;
              res.init_pulse     = 1'b1;
            end else begin
              status_nxt[dec.port][ppe_pkg::ST_SLCT_BIT] =
                write_data[ppe_pkg::CT_SLCTIN_BIT];
              control_nxt[dec.port][ppe_pkg::CT_SLCTIN_BIT] =
                write_data[ppe_pkg::CT_SLCTIN_BIT];
              strobe_go = write_data[ppe_pkg::CT_STROBE_BIT] &&
                          status_r[dec.port][ppe_pkg::ST_NOTBUSY_BIT];
              if (strobe_go) begin
                // Send the latched byte and go busy
                res.byte_valid     = 1'b1;
                res.out_byte       = data_r[dec.port];
                fill_nxt[dec.port] = fill_inc;
                if (fill_inc == record_limit || data_r[dec.port] == ppe_pkg::LINE_FEED) begin
                  res.record_end     = 1'b1;
                  fill_nxt[dec.port] = '0;
                end
                status_nxt[dec.port][ppe_pkg::ST_NOTBUSY_BIT] = 1'b0;
              end
              if (!write_data[ppe_pkg::CT_STROBE_BIT]) begin
                status_nxt[dec.port][ppe_pkg::ST_NOTBUSY_BIT] = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Commit port state when the beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ppe_pkg::NUM_PORTS; k++) begin
        data_r[k]    <= '0;
        status_r[k]  <= ppe_pkg::STATUS_RESET;
        control_r[k] <= ppe_pkg::CONTROL_RESET;
        fill_r[k]    <= '0;
      end
    end else if (advance) begin
      data_r    <= data_nxt;
      status_r  <= status_nxt;
      control_r <= control_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

FILE: design/parallel_printer_port_emulation.sv
// Each beat moves from the input register to the result register.
// Throughput: one access per cycle unless out_ch.ready stalls; these
// registers bracket one pass of address decode and port register update.
// Reset (rst_n, synchronous, active low): pipeline emptied, ports enabled,
// record limit 32768, port registers to data 0x00, status 0x90, control 0x0C.
`include "parallel_printer_port_emulation_defines.svh"

module parallel_printer_port_emulation (
  input  logic        clk,
  input  logic        rst_n,
  ppe_in_if.sink      in_ch,
  ppe_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [ppe_pkg::NUM_PORTS-1:0] port_enable_r;
  logic [15:0]                   record_limit_r;
  logic                          s1_valid_r, s1_valid_nxt;
  ppe_pkg::in_item_t             s1_item_r;
  logic                          out_valid_r, out_valid_nxt;
  ppe_pkg::result_t              out_res_r, res;
  ppe_pkg::decode_t              dec;
  logic                          out_free, advance, in_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_enable_r  <= ppe_pkg::PORT_ENABLE_RESET;
      record_limit_r <= ppe_pkg::MAX_RECORD;
    end else if (cfg_we) begin
      unique case (ppe_pkg::cfg_idx_t'(cfg_index))
        ppe_pkg::CFG_PORT_ENABLE:  port_enable_r  <= cfg_wdata[ppe_pkg::NUM_PORTS-1:0];
        ppe_pkg::CFG_RECORD_LIMIT: record_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: advance when the result register is free or being drained
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind       <= in_ch.kind;
      s1_item_r.io_address <= in_ch.io_address;
      s1_item_r.write_data <= in_ch.write_data;
    end
  end

  ppe_decode u_decode (
    .io_address  (s1_item_r.io_address),
    .port_enable (port_enable_r),
    .dec         (dec)
  );

  ppe_port_regs u_port_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .kind         (s1_item_r.kind),
    .write_data   (s1_item_r.write_data),
    .dec          (dec),
    .record_limit (record_limit_r),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_res_r.hit;
  assign out_ch.port_number = out_res_r.port_number;
  assign out_ch.read_data   = out_res_r.read_data;
  assign out_ch.byte_valid  = out_res_r.byte_valid;
  assign out_ch.out_byte    = out_res_r.out_byte;
  assign out_ch.record_end  = out_res_r.record_end;
  assign out_ch.init_pulse  = out_res_r.init_pulse;

  // Checks
  `PPE_ASSERT(a_miss_zero, out_valid_r && !out_res_r.hit |-> out_res_r == '0, "miss beat carries nonzero fields")
  `PPE_ASSERT(a_write_side, out_valid_r && (out_res_r.byte_valid || out_res_r.init_pulse) |-> out_res_r.hit && out_res_r.read_data == 8'h00 && !(out_res_r.byte_valid && out_res_r.init_pulse), "strobe or init beat inconsistent")
  `PPE_ASSERT(a_rec_end, out_valid_r && out_res_r.record_end |-> out_res_r.byte_valid, "record end without a sent byte")
  `PPE_ASSERT(a_s1_hold, s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r), "stalled input beat lost")
  `PPE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")

endmodule

FILE: verif/parallel_printer_port_emulation_tb.sv
module parallel_printer_port_emulation_tb;
  import ppe_pkg::*;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Directed access with an optional hand-written result
  typedef struct packed {
    logic     typed;
    in_item_t access;
    result_t  want;
  } access_row_t;

  localparam result_t NO_HIT = '0;

  localparam access_row_t DIRECTED_ACCESSES [25] = '{
    '{1'b1, '{KIND_READ,  16'h0378, 8'h00}, '{1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_READ,  16'h0379, 8'h00},
      '{1'b1, 2'd0, STATUS_RESET, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_READ,  16'h037A, 8'h00},
      '{1'b1, 2'd0, CONTROL_RESET, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_READ,  16'h037B, 8'h00}, NO_HIT},
    '{1'b1, '{KIND_READ,  16'h0000, 8'h00}, NO_HIT},
    '{1'b1, '{KIND_READ,  16'hFFFF, 8'hFF}, NO_HIT},
    '{1'b1, '{KIND_READ,  16'h0277, 8'h00}, NO_HIT},
    '{1'b1, '{KIND_READ,  16'h027A, 8'h00},
      '{1'b1, 2'd1, CONTROL_RESET, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_READ,  16'h03BD, 8'h00},
      '{1'b1, 2'd2, STATUS_RESET, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_WRITE, 16'h0379, 8'hFF}, '{1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_WRITE, 16'h0378, 8'h0A}, '{1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, '{KIND_WRITE, 16'h037A, 8'h0D}, '{1'b1, 2'd0, 8'h00, 1'b1, 8'h0A, 1'b1, 1'b0}},
    '{1'b0, '{KIND_READ,  16'h0379, 8'h00}, NO_HIT},
    '{1'b0, '{KIND_WRITE, 16'h037A, 8'h0D}, NO_HIT},
    '{1'b0, '{KIND_WRITE, 16'h037A, 8'h04}, NO_HIT},
    '{1'b0, '{KIND_READ,  16'h037A, 8'h00}, NO_HIT},
    '{1'b1, '{KIND_WRITE, 16'h037A, 8'h00}, '{1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{1'b1, '{KIND_WRITE, 16'h0378, 8'hFF}, '{1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, '{KIND_WRITE, 16'h037A, 8'h05}, NO_HIT},
    '{1'b0, '{KIND_WRITE, 16'h037A, 8'h0C}, NO_HIT},
    '{1'b1, '{KIND_WRITE, 16'h03BC, 8'h00}, '{1'b1, 2'd2, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, '{KIND_WRITE, 16'h03BE, 8'hFF}, NO_HIT},
    '{1'b1, '{KIND_WRITE, 16'h0000, 8'hFF}, NO_HIT},
    '{1'b1, '{KIND_WRITE, 16'hFFFF, 8'h00}, NO_HIT},
    '{1'b1, '{KIND_READ,  16'h0278, 8'h00}, '{1'b1, 2'd1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}}
  };

  // Register setting and traffic shape of each random phase
  typedef struct packed {
    logic [2:0]  enable;
    logic [15:0] limit;
    logic [9:0]  count;
    logic        tx_burst;
    logic        rx_burst;
    logic [9:0]  hold;
  } phase_t;

  localparam phase_t PHASES [8] = '{
    '{3'd7, 16'd1,     10'd50, 1'b0, 1'b0, 10'd0},
    '{3'd5, 16'd2,     10'd50, 1'b0, 1'b1, 10'd0},
    '{3'd0, 16'd3,     10'd30, 1'b1, 1'b0, 10'd0},
    '{3'd2, 16'd4,     10'd50, 1'b1, 1'b1, 10'd0},
    '{3'd7, 16'd32768, 10'd50, 1'b1, 1'b0, 10'd300},
    '{3'd3, 16'd7,     10'd50, 1'b0, 1'b0, 10'd0},
    '{3'd6, 16'd1,     10'd40, 1'b0, 1'b0, 10'd0},
    '{3'd7, 16'd3,     10'd50, 1'b0, 1'b1, 10'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  ppe_in_if  in_ch ();
  ppe_out_if out_ch ();

  parallel_printer_port_emulation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the port registers and configuration
  logic [2:0]  enable_mask;
  logic [15:0] limit;
  logic [7:0]  port_data    [NUM_PORTS];
  logic [7:0]  port_status  [NUM_PORTS];
  logic [7:0]  port_control [NUM_PORTS];
  logic [15:0] port_fill    [NUM_PORTS];

  result_t     pending_results [$];
  in_item_t    access_q [$];
  int unsigned mismatch_count;
  int unsigned hold_cycles;
  bit          rx_burst;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("parallel_printer_port_emulation_tb failed");
    $finish;
  end

  // Predict one access and update the shadow registers
  function automatic result_t emulate_access(in_item_t acc);
    result_t     r;
    logic        found;
    int unsigned k;
    int unsigned p;
    logic [15:0] off;
    logic [7:0]  v;
    r = '0;
    found = 1'b0;
    p = 0;
    off = '0;
    v = acc.write_data;
    for (k = 0; k < NUM_PORTS; k++) begin
      if (!found && enable_mask[k] && acc.io_address >= PORT_BASE[k] &&
          (acc.io_address - PORT_BASE[k]) < 16'd3) begin
        found = 1'b1;
        p = k;
        off = acc.io_address - PORT_BASE[k];
      end
    end
    if (!found) return r;
    r.hit = 1'b1;
    r.port_number = p[1:0];
    if (acc.kind == KIND_READ) begin
      case (off[1:0])
        OFF_DATA:   r.read_data = port_data[p];
        OFF_STATUS: r.read_data = port_status[p];
        default:    r.read_data = port_control[p];
      endcase
    end else if (off[1:0] == OFF_DATA) begin
      port_data[p] = v;
    end else if (off[1:0] == OFF_CONTROL) begin
      if (!v[CT_INIT_BIT]) begin
        // init request clears the fill count and leaves the other registers alone
        port_fill[p] = '0;
        r.init_pulse = 1'b1;
      end else begin
        port_status[p][ST_SLCT_BIT] = v[CT_SLCTIN_BIT];
        port_control[p][CT_SLCTIN_BIT] = v[CT_SLCTIN_BIT];
        if (v[CT_STROBE_BIT] && port_status[p][ST_NOTBUSY_BIT]) begin
          port_fill[p] = port_fill[p] + 16'd1;
          r.byte_valid = 1'b1;
          r.out_byte = port_data[p];
          if (port_fill[p] == limit || port_data[p] == LINE_FEED) begin
            r.record_end = 1'b1;
            port_fill[p] = '0;
          end
          port_status[p][ST_NOTBUSY_BIT] = 1'b0;
        end
        if (!v[CT_STROBE_BIT]) port_status[p][ST_NOTBUSY_BIT] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_item_t access_of(logic kind, logic [15:0] addr, logic [7:0] data);
    in_item_t acc;
    acc.kind = kind;
    acc.io_address = addr;
    acc.write_data = data;
    return acc;
  endfunction

  // Hold the setting from the edge at which the write lands
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_PORT_ENABLE:  enable_mask = value[2:0];
      CFG_RECORD_LIMIT: limit = value;
    endcase
  endtask

  // Offer one access beat and record its result once accepted
  task automatic offer_access(in_item_t acc, bit burst, bit use_want, result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= acc.kind;
    in_ch.io_address <= acc.io_address;
    in_ch.write_data <= acc.write_data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = emulate_access(acc);
    pending_results.push_back(use_want ? want : predicted);
  endtask

  // Mostly print sequences on the ports, with reads, init requests and noise
  task automatic build_traffic(int unsigned n);
    int unsigned roll;
    int unsigned p;
    logic [15:0] base;
    logic [7:0]  d;
    logic [7:0]  c;
    access_q.delete();
    while (access_q.size() < n) begin
      roll = $urandom_range(0, 99);
      p = $urandom_range(0, NUM_PORTS - 1);
      base = PORT_BASE[p];
      d = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
      if (roll < 10) begin
        access_q.push_back(access_of(1'($urandom_range(0, 1)),
                                     16'($urandom_range(0, 65535)), d));
      end else if (roll < 55) begin
        access_q.push_back(access_of(KIND_WRITE, base,
                                     ($urandom_range(0, 3) == 0) ? LINE_FEED : d));
        c[CT_INIT_BIT] = 1'b1;
        c[CT_STROBE_BIT] = 1'b1;
        access_q.push_back(access_of(KIND_WRITE, base + 16'd2, c));
        if ($urandom_range(0, 9) == 0) access_q.push_back(access_of(KIND_WRITE, base + 16'd2, c));
        c = 8'($urandom_range(0, 255));
        c[CT_INIT_BIT] = 1'b1;
        c[CT_STROBE_BIT] = 1'b0;
        access_q.push_back(access_of(KIND_WRITE, base + 16'd2, c));
      end else if (roll < 65) begin
        c[CT_INIT_BIT] = 1'b0;
        access_q.push_back(access_of(KIND_WRITE, base + 16'd2, c));
      end else if (roll < 90) begin
        access_q.push_back(access_of(KIND_READ, base + 16'($urandom_range(0, 3)), d));
      end else begin
        access_q.push_back(access_of(KIND_WRITE, base + 16'($urandom_range(0, 3)), d));
      end
    end
  endtask

  // Stimulus and configuration
  initial begin
    logic [15:0] enable_word;
    int unsigned i;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_READ;
    in_ch.io_address <= '0;
    in_ch.write_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PORT_ENABLE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    mismatch_count = 0;
    hold_cycles = 0;
    rx_burst = 1'b0;
    enable_mask = PORT_ENABLE_RESET;
    limit = MAX_RECORD;
    for (i = 0; i < NUM_PORTS; i++) begin
      port_data[i] = '0;
      port_status[i] = STATUS_RESET;
      port_control[i] = CONTROL_RESET;
      port_fill[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (i = 0; i < 25; i++)
      offer_access(DIRECTED_ACCESSES[i].access, 1'b0, DIRECTED_ACCESSES[i].typed,
                   DIRECTED_ACCESSES[i].want);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Random phases, reconfigured only once the block has drained
    for (int unsigned ph = 0; ph < 8; ph++) begin
      enable_word = 16'($urandom_range(0, 65535));
      enable_word[2:0] = PHASES[ph].enable;
      write_reg(CFG_PORT_ENABLE, enable_word);
      write_reg(CFG_RECORD_LIMIT, PHASES[ph].limit);
      cfg_we <= 1'b0;
      build_traffic(32'(PHASES[ph].count));
      rx_burst = PHASES[ph].rx_burst;
      hold_cycles = 32'(PHASES[ph].hold);
      foreach (access_q[j]) offer_access(access_q[j], PHASES[ph].tx_burst, 1'b0, NO_HIT);
      in_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    // Drain, then wait for any stray beat before reporting
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("parallel_printer_port_emulation_tb passed");
    else
      $display("parallel_printer_port_emulation_tb failed");
    $finish;
  end

  // Result side: stall at random, check every beat against the oldest prediction
  initial begin
    int unsigned stall;
    result_t     got;
    result_t     want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = {out_ch.hit, out_ch.port_number, out_ch.read_data, out_ch.byte_valid,
             out_ch.out_byte, out_ch.record_end, out_ch.init_pulse};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat: expected none, got %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: result mismatch: expected hit=%0d port=%0d read=%02h bv=%0d byte=%02h",
                   $realtime, want.hit, want.port_number, want.read_data, want.byte_valid,
                   want.out_byte);
          $display("  expected rec_end=%0d init=%0d, got hit=%0d port=%0d read=%02h bv=%0d",
                   want.record_end, want.init_pulse, got.hit, got.port_number, got.read_data,
                   got.byte_valid);
          $display("  got byte=%02h rec_end=%0d init=%0d",
                   got.out_byte, got.record_end, got.init_pulse);
        end
      end
    end
  end

endmodule
